FILE: src/cyclic_animation_timer_unit_defines.svh
// Assertion macros shared by the cyclic animation timer RTL.
`ifndef CYCLIC_ANIMATION_TIMER_UNIT_DEFINES_SVH
`define CYCLIC_ANIMATION_TIMER_UNIT_DEFINES_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define CAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante held.
`define CAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/cat_pkg.sv
// Types and constants of the cyclic animation timer.
package cat_pkg;

    localparam int MAX_EVENTS = 8;
    localparam int EV_W       = $clog2(MAX_EVENTS + 1);

    localparam int FUNC_W     = 2;
    localparam int AMOUNT_W   = 24;
    localparam int KIND_W     = 2;
    localparam int INDEX_W    = 32;
    localparam int PROG_W     = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam int DIV_STEPS  = 32;
    localparam int PROG_STEPS = 18;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    // Epsilon of 0.001 s in Q16.16.
    localparam logic signed [33:0] EPS_Q16 = 34'sd66;

    localparam logic signed [20:0] T_HALF = 21'sd32768;
    localparam logic signed [20:0] T_ONE  = 21'sd65536;
    localparam logic signed [20:0] T_TWO  = 21'sd131072;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_PLAY   = 2'd1,
        FUNC_RESUME = 2'd2,
        FUNC_STOP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_STATUS    = 2'd0,
        KIND_START     = 2'd1,
        KIND_CYCLE_END = 2'd2,
        KIND_END       = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CFG_CYCLE_TIME     = 3'd0,
        CFG_CYCLE_LIMIT    = 3'd1,
        CFG_SPEED          = 3'd2,
        CFG_SAVE_EVENTS    = 3'd3,
        CFG_ALTERNATE_MODE = 3'd4,
        CFG_REVERSED_MODE  = 3'd5,
        CFG_STOP_AT_END    = 3'd6
    } cfg_idx_t;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_MUL  = 12'b0000_0000_0010,
        ST_ADD  = 12'b0000_0000_0100,
        ST_CHK  = 12'b0000_0000_1000,
        ST_CDIV = 12'b0000_0001_0000,
        ST_CEND = 12'b0000_0010_0000,
        ST_PREP = 12'b0000_0100_0000,
        ST_MDIV = 12'b0000_1000_0000,
        ST_PSET = 12'b0001_0000_0000,
        ST_PDIV = 12'b0010_0000_0000,
        ST_FIN  = 12'b0100_0000_0000,
        ST_EMIT = 12'b1000_0000_0000
    } state_t;

endpackage

FILE: src/cat_ifs.sv
// Channel interfaces of the cyclic animation timer: commands, results, configuration.
interface cat_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [cat_pkg::FUNC_W-1:0]    func;
    logic [cat_pkg::AMOUNT_W-1:0]  amount;

    modport source (output valid, output func, output amount, input ready);
    modport sink   (input valid, input func, input amount, output ready);
endinterface

interface cat_res_if;
    logic                                valid;
    logic                                ready;
    logic [cat_pkg::KIND_W-1:0]          kind;
    logic [cat_pkg::INDEX_W-1:0]         event_index;
    logic signed [cat_pkg::PROG_W-1:0]   progression;
    logic                                running;
    logic                                last;

    modport source (output valid, output kind, output event_index, output progression,
                    output running, output last, input ready);
    modport sink   (input valid, input kind, input event_index, input progression,
                    input running, input last, output ready);
endinterface

interface cat_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cat_pkg::CFG_IDX_W-1:0]   index;
    logic [cat_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/cyclic_animation_timer_unit.sv
// Play, resume, stop and idle ticks pass prep, progression division, finish and emit; a
// running tick first passes multiply, add and check, one that completes cycles also cycle
// division and cycle end. Modulo division runs when the accumulator exceeds the cycle time;
// a progression saturated low skips the 18-step division. One command at a time uses the
// shared restoring divide unit; a new command is taken while the closing status item waits.
// Reset: accumulator, cycle index and flags clear; registers take their documented values.
`include "cyclic_animation_timer_unit_defines.svh"

module cyclic_animation_timer_unit (
    input  logic      clk,
    input  logic      rst_n,
    cat_cmd_if.sink   cmd,
    cat_res_if.source result,
    cat_cfg_if.sink   cfg
);
    import cat_pkg::*;

    // Configuration registers.
    logic [30:0]        cycle_time_reg;
    logic [15:0]        cycle_limit_reg;
    logic signed [15:0] speed_reg;
    logic               save_events_reg;
    logic               alternate_mode_reg;
    logic               reversed_mode_reg;
    logic               stop_at_end_reg;

    // Control state.
    state_t             state_reg, state_next;
    logic [31:0]        acc_reg, acc_next;
    logic [31:0]        cycle_index_reg, cycle_index_next;
    logic               paused_reg, paused_next;
    logic               stopped_reg, stopped_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ev_start_reg, ev_start_next;
    logic [EV_W-1:0]    ev_ce_left_reg, ev_ce_left_next;
    logic               ev_end_reg, ev_end_next;
    logic [EV_W-1:0]    ev_cnt_reg, ev_cnt_next;
    logic               out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [AMOUNT_W-1:0] amt_reg, amt_next;
    logic signed [40:0]  prod_reg, prod_next;
    logic [30:0]         div_rem_reg, div_rem_next;
    logic [31:0]         div_dq_reg, div_dq_next;
    logic [31:0]         x_reg, x_next;
    logic                neg_reg, neg_next;
    logic                clamp_reg, clamp_next;
    logic [31:0]         ce_idx_reg, ce_idx_next;
    logic signed [PROG_W-1:0] prog_reg, prog_next;
    kind_t               out_kind_reg, out_kind_next;
    logic [INDEX_W-1:0]  out_index_reg, out_index_next;
    logic signed [PROG_W-1:0] out_prog_reg, out_prog_next;
    logic                out_run_reg, out_run_next;
    logic                out_last_reg, out_last_next;

    // Shared datapath signals.
    logic [30:0]        ct_eff;
    logic [31:0]        div_shift;
    logic [32:0]        div_diff;
    logic               div_ge;
    logic [30:0]        div_rem_step;
    logic [31:0]        div_dq_step;
    logic signed [32:0] inc;
    logic signed [33:0] sum;
    logic [31:0]        sum_sat;
    logic signed [33:0] acc34;
    logic signed [33:0] th34;
    logic signed [33:0] d34;
    logic [15:0]        kend;
    logic               cyc_ends;
    logic [32:0]        m33;
    logic [31:0]        x_mag;
    logic [20:0]        q21;
    logic signed [20:0] t0, t_dbl, t1, t2;
    logic               out_free;
    logic               ev_room;
    logic               running;

    assign ct_eff = (cycle_time_reg == '0) ? 31'd1 : cycle_time_reg;
    assign running = !paused_reg && !stopped_reg;

    // One restoring division step: one quotient bit per cycle.
    assign div_shift    = {div_rem_reg, div_dq_reg[31]};
    assign div_diff     = {1'b0, div_shift} - {2'b00, ct_eff};
    assign div_ge       = !div_diff[32];
    assign div_rem_step = div_ge ? div_diff[30:0] : div_shift[30:0];
    assign div_dq_step  = {div_dq_reg[30:0], div_ge};

    // Increment is floor(speed * amount / 256); the sum saturates to 32 bits.
    assign inc = prod_reg[40:8];
    assign sum = {{2{acc_reg[31]}}, acc_reg} + {inc[32], inc};
    always_comb
    begin
        if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111)
            sum_sat = sum[31:0];
        else if (sum[33])
            sum_sat = 32'h8000_0000;
        else
            sum_sat = 32'h7FFF_FFFF;
    end

    assign acc34 = {{2{acc_reg[31]}}, acc_reg};
    assign th34  = $signed({3'b000, ct_eff}) - EPS_Q16;
    assign d34   = acc34 - th34;

    // Cycles left before the end; a cycle index already at the limit ends on the next cycle.
    assign kend = ({16'd0, cycle_limit_reg} > cycle_index_reg)
                ? (cycle_limit_reg - cycle_index_reg[15:0]) : 16'd1;
    assign cyc_ends = (cycle_limit_reg != '0) && (div_dq_reg >= {16'd0, kend - 16'd1});
    assign m33 = cyc_ends ? {17'd0, kend} : ({1'b0, div_dq_reg} + 33'd1);

    assign x_mag = x_reg[31] ? (32'd0 - x_reg) : x_reg;

    // Progression post-processing: sign, fold, reverse and saturate.
    assign q21 = {3'b000, div_dq_reg[17:0]};
    always_comb
    begin
        if (clamp_reg)
            t0 = -T_TWO;
        else if (neg_reg)
            t0 = -$signed(q21 + {20'd0, (div_rem_reg != '0)});
        else
            t0 = $signed(q21);
        t_dbl = t0 <<< 1;
        if (alternate_mode_reg)
            t1 = (t0 < T_HALF) ? t_dbl : (T_TWO - t_dbl);
        else
            t1 = t0;
        if (reversed_mode_reg)
            t2 = T_ONE - t1;
        else
            t2 = t1;
    end

    assign out_free = !out_valid_reg || result.ready;
    assign ev_room  = ev_cnt_reg < EV_W'(MAX_EVENTS);

    assign cmd.ready          = (state_reg == ST_IDLE);
    assign cfg.ready          = 1'b1;
    assign result.valid       = out_valid_reg;
    assign result.kind        = out_kind_reg;
    assign result.event_index = out_index_reg;
    assign result.progression = out_prog_reg;
    assign result.running     = out_run_reg;
    assign result.last        = out_last_reg;

    always_comb
    begin
        state_next       = state_reg;
        acc_next         = acc_reg;
        cycle_index_next = cycle_index_reg;
        paused_next      = paused_reg;
        stopped_next     = stopped_reg;
        cnt_next         = cnt_reg;
        ev_start_next    = ev_start_reg;
        ev_ce_left_next  = ev_ce_left_reg;
        ev_end_next      = ev_end_reg;
        ev_cnt_next      = ev_cnt_reg;
        out_valid_next   = out_valid_reg;
        amt_next         = amt_reg;
        prod_next        = prod_reg;
        div_rem_next     = div_rem_reg;
        div_dq_next      = div_dq_reg;
        x_next           = x_reg;
        neg_next         = neg_reg;
        clamp_next       = clamp_reg;
        ce_idx_next      = ce_idx_reg;
        prog_next        = prog_reg;
        out_kind_next    = out_kind_reg;
        out_index_next   = out_index_reg;
        out_prog_next    = out_prog_reg;
        out_run_next     = out_run_reg;
        out_last_next    = out_last_reg;

        if (result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    amt_next        = cmd.amount;
                    ev_start_next   = 1'b0;
                    ev_ce_left_next = '0;
                    ev_end_next     = 1'b0;
                    state_next      = ST_PREP;
                    unique case (func_t'(cmd.func))
                        FUNC_TICK:
                        begin
                            if (running)
                                state_next = ST_MUL;
                        end
                        FUNC_PLAY:
                        begin
                            acc_next         = 32'd0 - {8'd0, cmd.amount};
                            cycle_index_next = '0;
                            paused_next      = 1'b0;
                            stopped_next     = 1'b0;
                        end
                        FUNC_RESUME:
                        begin
                            paused_next  = 1'b0;
                            stopped_next = 1'b0;
                        end
                        FUNC_STOP:
                        begin
                            stopped_next = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_PREP;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                prod_next  = speed_reg * $signed({1'b0, amt_reg});
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                acc_next      = sum_sat;
                ev_start_next = acc_reg[31] && !sum_sat[31] && save_events_reg;
                state_next    = ST_CHK;
            end
            ST_CHK:
            begin
                if (acc34 >= th34)
                begin
                    div_rem_next = '0;
                    div_dq_next  = d34[31:0];
                    cnt_next     = CNT_W'(DIV_STEPS - 1);
                    state_next   = ST_CDIV;
                end
                else
                begin
                    state_next = ST_PREP;
                end
            end
            ST_CDIV:
            begin
                div_rem_next = div_rem_step;
                div_dq_next  = div_dq_step;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_CEND;
            end
            ST_CEND:
            begin
                // The remainder r gives acc - (q + 1) * ct = r - epsilon without a multiply.
                ce_idx_next      = cycle_index_reg;
                cycle_index_next = cycle_index_reg + m33[31:0];
                if (!save_events_reg)
                    ev_ce_left_next = '0;
                else if (m33 >= 33'(MAX_EVENTS))
                    ev_ce_left_next = EV_W'(MAX_EVENTS);
                else
                    ev_ce_left_next = m33[EV_W-1:0];
                ev_end_next = cyc_ends && save_events_reg;
                if (cyc_ends)
                begin
                    acc_next    = {1'b0, ct_eff};
                    paused_next = 1'b1;
                    if (stop_at_end_reg)
                        stopped_next = 1'b1;
                end
                else
                begin
                    acc_next = {1'b0, div_rem_reg} - 32'd66;
                end
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if ($signed(acc_reg) > $signed({1'b0, ct_eff}))
                begin
                    div_rem_next = '0;
                    div_dq_next  = acc_reg;
                    cnt_next     = CNT_W'(DIV_STEPS - 1);
                    state_next   = ST_MDIV;
                end
                else
                begin
                    x_next     = acc_reg;
                    state_next = ST_PSET;
                end
            end
            ST_MDIV:
            begin
                div_rem_next = div_rem_step;
                div_dq_next  = div_dq_step;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    x_next     = {1'b0, div_rem_step};
                    state_next = ST_PSET;
                end
            end
            ST_PSET:
            begin
                // At or below the negative of the doubled cycle time the result saturates whatever the modes.
                neg_next   = x_reg[31];
                clamp_next = x_reg[31] && (x_mag >= {ct_eff, 1'b0});
                if (x_reg[31] && (x_mag >= {ct_eff, 1'b0}))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    div_rem_next = {1'b0, x_mag[31:2]};
                    div_dq_next  = {x_mag[1:0], 30'd0};
                    cnt_next     = CNT_W'(PROG_STEPS - 1);
                    state_next   = ST_PDIV;
                end
            end
            ST_PDIV:
            begin
                div_rem_next = div_rem_step;
                div_dq_next  = div_dq_step;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (t2 > T_TWO)
                    prog_next = PROG_W'(T_TWO);
                else if (t2 < -T_TWO)
                    prog_next = PROG_W'(-T_TWO);
                else
                    prog_next = t2[PROG_W-1:0];
                ev_cnt_next = '0;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_prog_next  = prog_reg;
                    out_run_next   = running;
                    out_last_next  = 1'b0;
                    ev_cnt_next    = ev_cnt_reg + 1'b1;
                    if (ev_room && ev_start_reg)
                    begin
                        out_kind_next  = KIND_START;
                        out_index_next = '0;
                        ev_start_next  = 1'b0;
                    end
                    else if (ev_room && ev_ce_left_reg != '0)
                    begin
                        out_kind_next   = KIND_CYCLE_END;
                        out_index_next  = ce_idx_reg;
                        ce_idx_next     = ce_idx_reg + 32'd1;
                        ev_ce_left_next = ev_ce_left_reg - 1'b1;
                    end
                    else if (ev_room && ev_end_reg)
                    begin
                        out_kind_next  = KIND_END;
                        out_index_next = cycle_index_reg;
                        ev_end_next    = 1'b0;
                    end
                    else
                    begin
                        out_kind_next  = KIND_STATUS;
                        out_index_next = '0;
                        out_last_next  = 1'b1;
                        ev_cnt_next    = ev_cnt_reg;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_time_reg     <= 31'd65536;
            cycle_limit_reg    <= '0;
            speed_reg          <= 16'sd256;
            save_events_reg    <= 1'b1;
            alternate_mode_reg <= 1'b0;
            reversed_mode_reg  <= 1'b0;
            stop_at_end_reg    <= 1'b0;
            state_reg          <= ST_IDLE;
            acc_reg            <= '0;
            cycle_index_reg    <= '0;
            paused_reg         <= 1'b0;
            stopped_reg        <= 1'b0;
            cnt_reg            <= '0;
            ev_start_reg       <= 1'b0;
            ev_ce_left_reg     <= '0;
            ev_end_reg         <= 1'b0;
            ev_cnt_reg         <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg_idx_t'(cfg.index))
                    CFG_CYCLE_TIME:     cycle_time_reg     <= cfg.data;
                    CFG_CYCLE_LIMIT:    cycle_limit_reg    <= cfg.data[15:0];
                    CFG_SPEED:          speed_reg          <= $signed(cfg.data[15:0]);
                    CFG_SAVE_EVENTS:    save_events_reg    <= cfg.data[0];
                    CFG_ALTERNATE_MODE: alternate_mode_reg <= cfg.data[0];
                    CFG_REVERSED_MODE:  reversed_mode_reg  <= cfg.data[0];
                    CFG_STOP_AT_END:    stop_at_end_reg    <= cfg.data[0];
                    default:
                    begin
                        stop_at_end_reg <= stop_at_end_reg;
                    end
                endcase
            end
            state_reg       <= state_next;
            acc_reg         <= acc_next;
            cycle_index_reg <= cycle_index_next;
            paused_reg      <= paused_next;
            stopped_reg     <= stopped_next;
            cnt_reg         <= cnt_next;
            ev_start_reg    <= ev_start_next;
            ev_ce_left_reg  <= ev_ce_left_next;
            ev_end_reg      <= ev_end_next;
            ev_cnt_reg      <= ev_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg       <= amt_next;
        prod_reg      <= prod_next;
        div_rem_reg   <= div_rem_next;
        div_dq_reg    <= div_dq_next;
        x_reg         <= x_next;
        neg_reg       <= neg_next;
        clamp_reg     <= clamp_next;
        ce_idx_reg    <= ce_idx_next;
        prog_reg      <= prog_next;
        out_kind_reg  <= out_kind_next;
        out_index_reg <= out_index_next;
        out_prog_reg  <= out_prog_next;
        out_run_reg   <= out_run_next;
        out_last_reg  <= out_last_next;
    end

    `CAT_ASSERT_NEXT(a_busy_after_cmd, cmd.valid && cmd.ready, !cmd.ready,
        "command taken while the previous one is still in work")
    `CAT_ASSERT_NOW(a_event_only_in_emit, out_valid_reg && !out_last_reg,
        state_reg == ST_EMIT, "event item pending after the status item was issued")
    `CAT_ASSERT_NOW(a_event_cap, out_valid_reg, ev_cnt_reg <= EV_W'(MAX_EVENTS),
        "more event items than the cap")
    `CAT_ASSERT_NOW(a_prog_range, out_valid_reg,
        (out_prog_reg <= 19'sd131072) && (out_prog_reg >= -19'sd131072),
        "progression outside its saturation range")

endmodule
